// ----- hdl/dnsrm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dnsrm_pkg
// Types and constants for the dns response matcher: parse phases, header
// layout, record constants and the packed result word.
// ----------------------------------------------------------------------------
package dnsrm_pkg;

    localparam int DEF_PENDING_SLOTS    = 16;
    localparam int DEF_MAX_PACKET_BYTES = 512;

    localparam logic [15:0] HDR_BYTES  = 16'd12;
    localparam logic [15:0] IDX_ID_HI  = 16'd0;
    localparam logic [15:0] IDX_ID_LO  = 16'd1;
    localparam logic [15:0] IDX_FLG_HI = 16'd2;
    localparam logic [15:0] IDX_FLG_LO = 16'd3;
    localparam logic [15:0] IDX_AN_HI  = 16'd6;
    localparam logic [15:0] IDX_AN_LO  = 16'd7;

    localparam logic [7:0]  PTR_MARK     = 8'hC0;
    localparam logic [15:0] A_RDLEN      = 16'd4;
    localparam logic [15:0] QFIXED_BYTES = 16'd4;
    localparam logic [15:0] RRHDR_BYTES  = 16'd10;
    localparam logic [15:0] RRHDR_KEYED  = 16'd6;
    localparam logic [31:0] IN_A_KEY     = 32'h0001_0001;
    localparam int          QR_BIT       = 15;

    localparam logic KIND_QUERY    = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;

    typedef enum logic [1:0] {
        ST_IGNORED = 2'd0,
        ST_NOADDR  = 2'd1,
        ST_ADDR    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_HDR    = 4'd0,
        PH_QNAME  = 4'd1,
        PH_QLABEL = 4'd2,
        PH_QPTR   = 4'd3,
        PH_QFIXED = 4'd4,
        PH_ANAME  = 4'd5,
        PH_ALABEL = 4'd6,
        PH_APTR   = 4'd7,
        PH_RRHDR  = 4'd8,
        PH_RDATA  = 4'd9,
        PH_ADDR   = 4'd10,
        PH_DONE   = 4'd11
    } phase_t;

    // lowest bit first: accepted, query_id, status, ipv4_address
    typedef struct packed {
        logic [31:0] ipv4_address;
        status_t     status;
        logic [15:0] query_id;
        logic        accepted;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage
`default_nettype wire

// ----- hdl/dns_response_matcher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dns_response_matcher
// Path from input word to result word: input stage, then result reg.
// Throughput: one word per cycle, query or response byte alike, while the result side
// is not stalled; the pending table lookup and the byte parser are combinational.
// Reset (aresetn low, synchronous): pending table empty, next id 1, parser
// back at the header, both stages empty. Stored ids need no reset.
// ----------------------------------------------------------------------------
module dns_response_matcher #(
    parameter int PENDING_SLOTS    = dnsrm_pkg::DEF_PENDING_SLOTS,
    parameter int MAX_PACKET_BYTES = dnsrm_pkg::DEF_MAX_PACKET_BYTES
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,  // data_byte
    input  wire logic                          s_tuser,  // kind
    input  wire logic                          s_tlast,  // last
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // accepted, query_id, status, ipv4_address, zero fill
    output logic [dnsrm_pkg::TDATA_W-1:0]      m_tdata
);

    localparam logic [15:0] MAX_BYTES = 16'(MAX_PACKET_BYTES);

    // input stage
    logic        in_valid_reg, in_valid_next;
    logic        in_kind_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;

    // result stage
    logic                out_valid_reg, out_valid_next;
    dnsrm_pkg::result_t  out_data_reg, out_data_next;

    // pending table
    logic [15:0]              next_id_reg, next_id_next;
    logic [PENDING_SLOTS-1:0] pend_valid_reg, pend_valid_next;
    logic [15:0]              pend_ids_reg [PENDING_SLOTS];
    // newer_reg[i][j]: slot i was registered after slot j
    logic [PENDING_SLOTS-1:0] newer_reg [PENDING_SLOTS];
    logic [PENDING_SLOTS-1:0] newer_next [PENDING_SLOTS];

    // parser
    dnsrm_pkg::phase_t phase_reg, phase_next;
    logic [15:0] byte_offset_reg, byte_offset_next;
    logic [15:0] skip_reg, skip_next;
    logic [15:0] answers_reg, answers_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] flags_reg, flags_next;
    logic [15:0] resp_id_reg, resp_id_next;
    logic        rr_in_a_reg, rr_in_a_next;
    logic [31:0] found_reg, found_next;
    logic        found_ok_reg, found_ok_next;

    logic                     s_accept;
    logic                     advance;
    logic                     produce;
    logic                     table_full;
    logic                     ins_en;
    logic [PENDING_SLOTS-1:0] free_oh;
    logic [PENDING_SLOTS-1:0] match_vec;
    logic [PENDING_SLOTS-1:0] hit_vec;
    logic                     any_hit;
    logic [15:0]              skip_dec;
    logic [15:0]              answers_dec;
    logic [31:0]              shift_in;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign produce  = (in_kind_reg == dnsrm_pkg::KIND_QUERY) || in_last_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = dnsrm_pkg::TDATA_W'(out_data_reg);

    assign table_full  = &pend_valid_reg;
    assign free_oh     = ~pend_valid_reg & (pend_valid_reg + PENDING_SLOTS'(1));
    assign ins_en      = advance && (in_kind_reg == dnsrm_pkg::KIND_QUERY) && !table_full;
    assign skip_dec    = skip_reg - 16'd1;
    assign answers_dec = answers_reg - 16'd1;
    assign shift_in    = {shift_reg[23:0], in_data_reg};

    // newest matching slot wins
    always_comb begin
        for (int i = 0; i < PENDING_SLOTS; i++) begin
            match_vec[i] = pend_valid_reg[i] && (pend_ids_reg[i] == resp_id_reg);
        end
        for (int i = 0; i < PENDING_SLOTS; i++) begin
            hit_vec[i] = match_vec[i] && !(|(match_vec & ~newer_reg[i]));
        end
        any_hit = |match_vec;
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && produce) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // parser and table update
    always_comb begin
        next_id_next     = next_id_reg;
        pend_valid_next  = pend_valid_reg;
        newer_next       = newer_reg;
        phase_next       = phase_reg;
        byte_offset_next = byte_offset_reg;
        skip_next        = skip_reg;
        answers_next     = answers_reg;
        shift_next       = shift_reg;
        flags_next       = flags_reg;
        resp_id_next     = resp_id_reg;
        rr_in_a_next     = rr_in_a_reg;
        found_next       = found_reg;
        found_ok_next    = found_ok_reg;

        out_data_next              = '0;
        out_data_next.status       = dnsrm_pkg::ST_IGNORED;

        if (advance && in_kind_reg == dnsrm_pkg::KIND_QUERY) begin
            if (!table_full) begin
                pend_valid_next = pend_valid_reg | free_oh;
                for (int i = 0; i < PENDING_SLOTS; i++) begin
                    if (free_oh[i]) begin
                        newer_next[i] = '1;
                    end else begin
                        newer_next[i] = newer_reg[i] & ~free_oh;
                    end
                end
                out_data_next.accepted = 1'b1;
                out_data_next.query_id = next_id_reg;
                next_id_next           = next_id_reg + 16'd1;
            end
        end else if (advance) begin
            if (byte_offset_reg < MAX_BYTES) begin
                case (phase_reg)
                    dnsrm_pkg::PH_HDR: begin
                        case (byte_offset_reg)
                            dnsrm_pkg::IDX_ID_HI:  resp_id_next = {in_data_reg, 8'h00};
                            dnsrm_pkg::IDX_ID_LO:  resp_id_next = {resp_id_reg[15:8], in_data_reg};
                            dnsrm_pkg::IDX_FLG_HI: flags_next   = {in_data_reg, 8'h00};
                            dnsrm_pkg::IDX_FLG_LO: flags_next   = {flags_reg[15:8], in_data_reg};
                            dnsrm_pkg::IDX_AN_HI:  answers_next = {in_data_reg, 8'h00};
                            dnsrm_pkg::IDX_AN_LO:  answers_next = {answers_reg[15:8], in_data_reg};
                            default: ;
                        endcase
                        if (byte_offset_reg >= dnsrm_pkg::HDR_BYTES - 16'd1) begin
                            phase_next = dnsrm_pkg::PH_QNAME;
                        end
                    end
                    dnsrm_pkg::PH_QNAME, dnsrm_pkg::PH_ANAME: begin
                        if (in_data_reg == 8'h00) begin
                            if (phase_reg == dnsrm_pkg::PH_QNAME) begin
                                skip_next  = dnsrm_pkg::QFIXED_BYTES;
                                phase_next = dnsrm_pkg::PH_QFIXED;
                            end else begin
                                skip_next    = dnsrm_pkg::RRHDR_BYTES;
                                shift_next   = '0;
                                rr_in_a_next = 1'b0;
                                phase_next   = dnsrm_pkg::PH_RRHDR;
                            end
                        end else if ((in_data_reg & dnsrm_pkg::PTR_MARK) == dnsrm_pkg::PTR_MARK) begin
                            phase_next = (phase_reg == dnsrm_pkg::PH_QNAME) ?
                                         dnsrm_pkg::PH_QPTR : dnsrm_pkg::PH_APTR;
                        end else begin
                            skip_next  = {8'h00, in_data_reg};
                            phase_next = (phase_reg == dnsrm_pkg::PH_QNAME) ?
                                         dnsrm_pkg::PH_QLABEL : dnsrm_pkg::PH_ALABEL;
                        end
                    end
                    dnsrm_pkg::PH_QLABEL, dnsrm_pkg::PH_ALABEL: begin
                        skip_next = skip_dec;
                        if (skip_dec == 16'd0) begin
                            phase_next = (phase_reg == dnsrm_pkg::PH_QLABEL) ?
                                         dnsrm_pkg::PH_QNAME : dnsrm_pkg::PH_ANAME;
                        end
                    end
                    dnsrm_pkg::PH_QPTR: begin
                        skip_next  = dnsrm_pkg::QFIXED_BYTES;
                        phase_next = dnsrm_pkg::PH_QFIXED;
                    end
                    dnsrm_pkg::PH_APTR: begin
                        skip_next    = dnsrm_pkg::RRHDR_BYTES;
                        shift_next   = '0;
                        rr_in_a_next = 1'b0;
                        phase_next   = dnsrm_pkg::PH_RRHDR;
                    end
                    dnsrm_pkg::PH_QFIXED, dnsrm_pkg::PH_RDATA: begin
                        skip_next = skip_dec;
                        if (skip_dec == 16'd0) begin
                            phase_next = (answers_reg == 16'd0) ?
                                         dnsrm_pkg::PH_DONE : dnsrm_pkg::PH_ANAME;
                        end
                    end
                    dnsrm_pkg::PH_RRHDR: begin
                        shift_next = shift_in;
                        skip_next  = skip_dec;
                        if (skip_dec == dnsrm_pkg::RRHDR_KEYED) begin
                            rr_in_a_next = (shift_in == dnsrm_pkg::IN_A_KEY);
                        end
                        if (skip_dec == 16'd0) begin
                            if (rr_in_a_reg && shift_in[15:0] == dnsrm_pkg::A_RDLEN) begin
                                shift_next = '0;
                                skip_next  = dnsrm_pkg::A_RDLEN;
                                phase_next = dnsrm_pkg::PH_ADDR;
                            end else begin
                                answers_next = answers_dec;
                                if (shift_in[15:0] == 16'd0) begin
                                    phase_next = (answers_dec == 16'd0) ?
                                                 dnsrm_pkg::PH_DONE : dnsrm_pkg::PH_ANAME;
                                end else begin
                                    skip_next  = shift_in[15:0];
                                    phase_next = dnsrm_pkg::PH_RDATA;
                                end
                            end
                        end
                    end
                    dnsrm_pkg::PH_ADDR: begin
                        shift_next = shift_in;
                        skip_next  = skip_dec;
                        if (skip_dec == 16'd0) begin
                            found_next    = shift_in;
                            found_ok_next = 1'b1;
                            phase_next    = dnsrm_pkg::PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end

            if (byte_offset_reg != 16'hFFFF) begin
                byte_offset_next = byte_offset_reg + 16'd1;
            end

            if (in_last_reg) begin
                if (byte_offset_next >= dnsrm_pkg::HDR_BYTES && any_hit) begin
                    pend_valid_next        = pend_valid_reg & ~hit_vec;
                    out_data_next.query_id = resp_id_reg;
                    if (found_ok_next && flags_reg[dnsrm_pkg::QR_BIT]) begin
                        out_data_next.status       = dnsrm_pkg::ST_ADDR;
                        out_data_next.ipv4_address = found_next;
                    end else begin
                        out_data_next.status = dnsrm_pkg::ST_NOADDR;
                    end
                end
                phase_next       = dnsrm_pkg::PH_HDR;
                byte_offset_next = '0;
                skip_next        = '0;
                answers_next     = '0;
                shift_next       = '0;
                flags_next       = '0;
                resp_id_next     = '0;
                rr_in_a_next     = 1'b0;
                found_next       = '0;
                found_ok_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            next_id_reg     <= 16'd1;
            pend_valid_reg  <= '0;
            for (int i = 0; i < PENDING_SLOTS; i++) begin
                newer_reg[i] <= '0;
            end
            phase_reg       <= dnsrm_pkg::PH_HDR;
            byte_offset_reg <= '0;
            skip_reg        <= '0;
            answers_reg     <= '0;
            shift_reg       <= '0;
            flags_reg       <= '0;
            resp_id_reg     <= '0;
            rr_in_a_reg     <= 1'b0;
            found_reg       <= '0;
            found_ok_reg    <= 1'b0;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            next_id_reg     <= next_id_next;
            pend_valid_reg  <= pend_valid_next;
            newer_reg       <= newer_next;
            phase_reg       <= phase_next;
            byte_offset_reg <= byte_offset_next;
            skip_reg        <= skip_next;
            answers_reg     <= answers_next;
            shift_reg       <= shift_next;
            flags_reg       <= flags_next;
            resp_id_reg     <= resp_id_next;
            rr_in_a_reg     <= rr_in_a_next;
            found_reg       <= found_next;
            found_ok_reg    <= found_ok_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg <= s_tuser;
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && produce) begin
            out_data_reg <= out_data_next;
        end
        for (int i = 0; i < PENDING_SLOTS; i++) begin
            if (ins_en && free_oh[i]) begin
                pend_ids_reg[i] <= next_id_reg;
            end
        end
    end

endmodule
`default_nettype wire

// ----- dv/dns_match_check.sv -----
// ----------------------------------------------------------------------------
// dns_match_check
// Watches both stream channels of the dns response matcher. Every word taken
// on the input side runs through a model of the pending-id table and the
// response parser. Each result word is compared field by field with the
// oldest predicted result. Mismatches are counted, and the number of results
// still owed is reported back to the testbench top.
// ----------------------------------------------------------------------------
module dns_match_check (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [7:0]                    s_tdata,   // data_byte
    input  wire logic                          s_tuser,   // kind
    input  wire logic                          s_tlast,   // last
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    // accepted, query_id, status, ipv4_address, zero fill
    input  wire logic [dnsrm_pkg::TDATA_W-1:0] m_tdata,
    output int                                 mismatches,
    output int                                 results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = dnsrm_pkg::DEF_PENDING_SLOTS;
    localparam int MAX_BYTES = dnsrm_pkg::DEF_MAX_PACKET_BYTES;

    dnsrm_pkg::result_t owed_q[$];

    logic [15:0] id_next;
    logic [15:0] slot_id   [SLOTS];
    logic        slot_busy [SLOTS];
    logic [3:0]  slot_age  [SLOTS];

    logic [15:0]       pkt_offset;
    dnsrm_pkg::phase_t phase;
    logic [15:0]       skip_left;
    logic [15:0]       answers_left;
    logic [31:0]       shift_reg;
    logic [15:0]       hdr_flags;
    logic [15:0]       hdr_id;
    logic              rr_in_a;
    logic [31:0]       addr_seen;
    logic              addr_valid;

    function automatic void clear_parser();
        pkt_offset   = '0;
        phase        = dnsrm_pkg::PH_HDR;
        skip_left    = '0;
        answers_left = '0;
        shift_reg    = '0;
        hdr_flags    = '0;
        hdr_id       = '0;
        rr_in_a      = 1'b0;
        addr_seen    = '0;
        addr_valid   = 1'b0;
    endfunction

    function automatic void end_name(input logic question);
        if (question) begin
            skip_left = dnsrm_pkg::QFIXED_BYTES;
            phase     = dnsrm_pkg::PH_QFIXED;
        end else begin
            skip_left = dnsrm_pkg::RRHDR_BYTES;
            shift_reg = '0;
            rr_in_a   = 1'b0;
            phase     = dnsrm_pkg::PH_RRHDR;
        end
    endfunction

    function automatic void next_record();
        phase = (answers_left == 16'd0) ? dnsrm_pkg::PH_DONE : dnsrm_pkg::PH_ANAME;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        logic        question;
        logic [15:0] rdlen;
        question = (phase == dnsrm_pkg::PH_QNAME);
        case (phase)
            dnsrm_pkg::PH_HDR: begin
                case (pkt_offset)
                    dnsrm_pkg::IDX_ID_HI:  hdr_id = {b, 8'h00};
                    dnsrm_pkg::IDX_ID_LO:  hdr_id[7:0] = b;
                    dnsrm_pkg::IDX_FLG_HI: hdr_flags = {b, 8'h00};
                    dnsrm_pkg::IDX_FLG_LO: hdr_flags[7:0] = b;
                    dnsrm_pkg::IDX_AN_HI:  answers_left = {b, 8'h00};
                    dnsrm_pkg::IDX_AN_LO:  answers_left[7:0] = b;
                    default: ;
                endcase
                if (pkt_offset >= dnsrm_pkg::HDR_BYTES - 16'd1) phase = dnsrm_pkg::PH_QNAME;
            end
            dnsrm_pkg::PH_QNAME, dnsrm_pkg::PH_ANAME: begin
                if (b == 8'h00) begin
                    end_name(question);
                end else if ((b & dnsrm_pkg::PTR_MARK) == dnsrm_pkg::PTR_MARK) begin
                    phase = question ? dnsrm_pkg::PH_QPTR : dnsrm_pkg::PH_APTR;
                end else begin
                    skip_left = {8'h00, b};
                    phase     = question ? dnsrm_pkg::PH_QLABEL : dnsrm_pkg::PH_ALABEL;
                end
            end
            dnsrm_pkg::PH_QLABEL, dnsrm_pkg::PH_ALABEL: begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0) begin
                    phase = (phase == dnsrm_pkg::PH_QLABEL) ?
                            dnsrm_pkg::PH_QNAME : dnsrm_pkg::PH_ANAME;
                end
            end
            dnsrm_pkg::PH_QPTR: end_name(1'b1);
            dnsrm_pkg::PH_APTR: end_name(1'b0);
            dnsrm_pkg::PH_QFIXED: begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0) next_record();
            end
            dnsrm_pkg::PH_RRHDR: begin
                shift_reg = {shift_reg[23:0], b};
                skip_left = skip_left - 16'd1;
                if (skip_left == dnsrm_pkg::RRHDR_KEYED) begin
                    rr_in_a = (shift_reg == dnsrm_pkg::IN_A_KEY);
                end
                if (skip_left == 16'd0) begin
                    rdlen = shift_reg[15:0];
                    if (rr_in_a && rdlen == dnsrm_pkg::A_RDLEN) begin
                        shift_reg = '0;
                        skip_left = dnsrm_pkg::A_RDLEN;
                        phase     = dnsrm_pkg::PH_ADDR;
                    end else begin
                        answers_left = answers_left - 16'd1;
                        if (rdlen == 16'd0) begin
                            next_record();
                        end else begin
                            skip_left = rdlen;
                            phase     = dnsrm_pkg::PH_RDATA;
                        end
                    end
                end
            end
            dnsrm_pkg::PH_RDATA: begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0) next_record();
            end
            dnsrm_pkg::PH_ADDR: begin
                shift_reg = {shift_reg[23:0], b};
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0) begin
                    addr_seen  = shift_reg;
                    addr_valid = 1'b1;
                    phase      = dnsrm_pkg::PH_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    // lowest free slot takes the next id, every older entry ages by one
    function automatic dnsrm_pkg::result_t register_query();
        dnsrm_pkg::result_t r;
        int                 free_slot;
        r         = '0;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!slot_busy[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot >= 0) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_busy[i]) slot_age[i] = slot_age[i] + 4'd1;
            end
            slot_id[free_slot]   = id_next;
            slot_busy[free_slot] = 1'b1;
            slot_age[free_slot]  = '0;
            r.accepted = 1'b1;
            r.query_id = id_next;
            id_next    = id_next + 16'd1;
        end
        return r;
    endfunction

    // newest slot holding the response id is freed and reported
    function automatic dnsrm_pkg::result_t close_response();
        dnsrm_pkg::result_t r;
        int                 hit;
        logic [3:0]         gone;
        r   = '0;
        hit = -1;
        if (pkt_offset >= dnsrm_pkg::HDR_BYTES) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_busy[i] && slot_id[i] == hdr_id &&
                    (hit < 0 || slot_age[i] < slot_age[hit])) hit = i;
            end
            if (hit >= 0) begin
                gone           = slot_age[hit];
                slot_busy[hit] = 1'b0;
                slot_age[hit]  = '0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_busy[i] && slot_age[i] > gone) slot_age[i] = slot_age[i] - 4'd1;
                end
                r.query_id = hdr_id;
                if (addr_valid && hdr_flags[dnsrm_pkg::QR_BIT]) begin
                    r.status       = dnsrm_pkg::ST_ADDR;
                    r.ipv4_address = addr_seen;
                end else begin
                    r.status = dnsrm_pkg::ST_NOADDR;
                end
            end
        end
        clear_parser();
        return r;
    endfunction

    function automatic void report(input string what, input dnsrm_pkg::result_t want,
                                   input dnsrm_pkg::result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("%0t: %s: expected acc %0d id %h status %0d addr %h,",
                   $time, what, want.accepted, want.query_id, want.status,
                   want.ipv4_address);
            $display(" got acc %0d id %h status %0d addr %h",
                     got.accepted, got.query_id, got.status, got.ipv4_address);
        end
    endfunction

    always @(posedge aclk) begin
        dnsrm_pkg::result_t seen;
        dnsrm_pkg::result_t want;
        if (!aresetn) begin
            owed_q.delete();
            id_next = 16'd1;
            for (int i = 0; i < SLOTS; i++) begin
                slot_id[i]   = '0;
                slot_busy[i] = 1'b0;
                slot_age[i]  = '0;
            end
            clear_parser();
        end else begin
            if (m_tvalid && m_tready) begin
                seen = dnsrm_pkg::result_t'(m_tdata[dnsrm_pkg::RESULT_W-1:0]);
                if (owed_q.size() == 0) begin
                    report("result word with nothing expected", '0, seen);
                end else begin
                    want = owed_q.pop_front();
                    if (seen.accepted !== want.accepted || seen.query_id !== want.query_id ||
                        seen.status !== want.status ||
                        seen.ipv4_address !== want.ipv4_address) begin
                        report("result word mismatch", want, seen);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == dnsrm_pkg::KIND_QUERY) begin
                    owed_q.push_back(register_query());
                end else begin
                    if (pkt_offset < MAX_BYTES) parse_byte(s_tdata);
                    if (pkt_offset != 16'hFFFF) pkt_offset = pkt_offset + 16'd1;
                    if (s_tlast) owed_q.push_back(close_response());
                end
            end
        end
        results_owed = owed_q.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the dns response matcher. Fills and overflows the pending
// table, then streams random queries and responses (well-formed records,
// pointers, truncation, noise) under changing idle patterns and a long
// result-side hold, and finally sends one packet that runs past the parse
// limit.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 4;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SLOTS        = dnsrm_pkg::DEF_PENDING_SLOTS;
    localparam int TRAFFIC_WORDS = 230;
    localparam int LONG_BYTES   = dnsrm_pkg::DEF_MAX_PACKET_BYTES + 28;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = '0;
    logic                          s_tuser  = dnsrm_pkg::KIND_QUERY;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [dnsrm_pkg::TDATA_W-1:0] m_tdata;

    int          mismatches;
    int          results_owed;
    int          cycle_count   = 0;
    int          words_sent    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_wanted   = 1'b0;
    logic [15:0] tb_next_id    = 16'd1;
    logic [15:0] open_ids[$];
    logic [7:0]  pkt[$];

    dns_response_matcher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dns_match_check u_match_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("dns_response_matcher test failed");
        $finish;
    end

    // result side: random stalls, plus one long hold counted here
    initial begin
        int   hold_left;
        logic hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_wanted && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_word(input logic kind, input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_query();
        if (open_ids.size() < SLOTS) begin
            open_ids.push_back(tb_next_id);
            tb_next_id = tb_next_id + 16'd1;
        end
        send_word(dnsrm_pkg::KIND_QUERY, 8'($urandom), 1'($urandom));
    endtask

    // mix_rate: chance per mille of a query slipped in ahead of each byte
    task automatic send_packet(input int mix_rate);
        logic [15:0] rid;
        int          idx;
        for (int i = 0; i < pkt.size(); i++) begin
            if ($urandom_range(999) < mix_rate) send_query();
            send_word(dnsrm_pkg::KIND_RESPONSE, pkt[i], i == pkt.size() - 1);
        end
        if (pkt.size() >= dnsrm_pkg::HDR_BYTES) begin
            rid = {pkt[0], pkt[1]};
            idx = -1;
            foreach (open_ids[j]) if (open_ids[j] == rid) idx = j;
            if (idx >= 0) open_ids.delete(idx);
        end
    endtask

    function automatic void put16(input logic [15:0] v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endfunction

    function automatic void put_name();
        int labels;
        int len;
        labels = $urandom_range(3);
        for (int i = 0; i < labels; i++) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(191, 64) : $urandom_range(8, 1);
            pkt.push_back(8'(len));
            repeat (len) pkt.push_back(8'($urandom));
        end
        if ($urandom_range(1)) begin
            pkt.push_back({2'b11, 6'($urandom)});
            pkt.push_back(8'($urandom));
        end else begin
            pkt.push_back(8'h00);
        end
    endfunction

    function automatic void put_answer(input logic want_a);
        logic [15:0] rtype;
        logic [15:0] rclass;
        logic [15:0] rdlen;
        put_name();
        rtype  = want_a ? 16'd1 : ($urandom_range(1) ? 16'd5 : 16'($urandom));
        rclass = ($urandom_range(4) != 0) ? 16'd1 : 16'($urandom);
        put16(rtype);
        put16(rclass);
        put16(16'($urandom));
        put16(16'($urandom));
        if (rtype == 16'd1 && rclass == 16'd1)
            rdlen = ($urandom_range(5) != 0) ? dnsrm_pkg::A_RDLEN : 16'($urandom_range(8));
        else
            rdlen = 16'($urandom_range(6));
        put16(rdlen);
        repeat (rdlen) pkt.push_back(8'($urandom));
    endfunction

    function automatic void build_response(input logic [15:0] rid);
        int          n_rec;
        int          cut;
        int          shape;
        logic [15:0] flags;
        pkt.delete();
        put16(rid);
        flags                   = 16'($urandom);
        flags[dnsrm_pkg::QR_BIT] = ($urandom_range(7) != 0);
        put16(flags);
        put16(($urandom_range(3) == 0) ? 16'($urandom) : 16'd1);
        n_rec = $urandom_range(3);
        put16(($urandom_range(9) == 0) ? 16'($urandom) : 16'(n_rec));
        put16(16'($urandom));
        put16(16'($urandom));
        put_name();
        put16($urandom_range(1) ? 16'd1 : 16'($urandom));
        put16($urandom_range(1) ? 16'd1 : 16'($urandom));
        for (int i = 0; i < n_rec; i++) put_answer($urandom_range(1));
        shape = $urandom_range(19);
        if (shape < 2) begin
            cut = $urandom_range(pkt.size() - 1, 1);
            while (pkt.size() > cut) void'(pkt.pop_back());
        end else if (shape == 2) begin
            repeat ($urandom_range(6, 1)) pkt.push_back(8'($urandom));
        end
    endfunction

    function automatic void build_noise(input logic [15:0] rid);
        int len;
        pkt.delete();
        len = $urandom_range(40, 1);
        repeat (len) pkt.push_back(8'($urandom));
        if (len >= 2 && $urandom_range(1)) begin
            pkt[0] = rid[15:8];
            pkt[1] = rid[7:0];
        end
    endfunction

    function automatic logic [15:0] pick_id();
        if (open_ids.size() != 0 && $urandom_range(4) != 0)
            return open_ids[$urandom_range(open_ids.size() - 1)];
        case ($urandom_range(2))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_traffic(input int words_target);
        int stop_at;
        stop_at = words_sent + words_target;
        while (words_sent < stop_at) begin
            case ($urandom_range(9))
                0, 1, 2: send_query();
                3: begin
                    build_noise(pick_id());
                    send_packet(0);
                end
                default: begin
                    build_response(pick_id());
                    send_packet(20);
                end
            endcase
        end
    endtask

    initial begin
        int drain;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // fill the table and go one past full, then a lone short packet
        repeat (SLOTS + 1) send_query();
        pkt.delete();
        pkt.push_back(8'hFF);
        send_packet(0);

        // long hold on the result side while queries keep coming
        hold_wanted = 1'b1;
        repeat (40) send_query();

        send_idle_pct = 28;
        recv_idle_pct = 75;
        random_traffic(TRAFFIC_WORDS);
        send_idle_pct = 75;
        recv_idle_pct = 28;
        random_traffic(TRAFFIC_WORDS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(TRAFFIC_WORDS);

        // one packet that runs past the parse limit
        build_response(pick_id());
        while (pkt.size() < LONG_BYTES) pkt.push_back(8'($urandom));
        send_packet(0);

        @(negedge aclk);
        s_tvalid <= 1'b0;

        drain = 0;
        while (results_owed != 0 && drain < 10000) begin
            @(negedge aclk);
            drain++;
        end
        repeat (16) @(negedge aclk);
        if (mismatches == 0 && results_owed == 0) begin
            $display("dns_response_matcher test passed");
        end else begin
            $display("dns_response_matcher test failed");
        end
        $finish;
    end

endmodule
